### design/pfb_pkg.sv
// Shared types and constants for the page framebuffer blitter.
// Used by pfb_store, pfb_ctrl and page_framebuffer_blitter_top; no dependencies.
`default_nettype none
package pfb_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int STORE_AW    = 10;
    // byte index before the range check: page base plus column
    localparam int IDX_W       = 12;
    localparam logic [7:0] BYTE_MSB = 8'h80;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_PLOT  = 2'd1,
        OP_BLIT  = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIXEL,
        ST_READ,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] waddr;
        logic [7:0]          wdata;
        logic                re;
        logic [STORE_AW-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_result;

endpackage
`default_nettype wire

### design/page_framebuffer_blitter_top.sv
// Top level of the page framebuffer blitter: sequencer, frame store and
// output register. Depends on pfb_pkg, pfb_store and pfb_ctrl.
//
// A 1024-byte monochrome frame store in pages of eight rows, one byte per
// column with bit 0 at the top. Each input word is one operation and yields
// one output word: clear (a full write sweep), plot (a single pixel), blit of
// one bitmap byte (eight pixel steps through the read-modify-write pipeline
// of the store), and read (through the store's registered read port). After
// reset the store is zeroed by a write sweep during which no input word is
// taken. An output register lets the next word be taken while the last
// result still waits.
`default_nettype none
module page_framebuffer_blitter_top
    import pfb_pkg::*;
#(
    parameter int PANEL_WIDTH  = 128,
    parameter int PANEL_HEIGHT = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [1:0]          i_operation,
    input  wire logic [7:0]          i_x_pos,
    input  wire logic [7:0]          i_y_pos,
    input  wire logic [7:0]          i_row_offset,
    input  wire logic [4:0]          i_byte_offset,
    input  wire logic [7:0]          i_pattern_byte,
    input  wire logic [3:0]          i_bit_count,
    input  wire logic                i_pixel_color,
    input  wire logic [STORE_AW-1:0] i_address,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [7:0]               o_read_data
);

    t_mem_req   mem_req;
    logic [7:0] rd_data;
    t_result    result;
    logic       result_take;

    logic       r_out_valid;
    logic [7:0] r_read_data;

    pfb_ctrl #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_x_pos        (i_x_pos),
        .i_y_pos        (i_y_pos),
        .i_row_offset   (i_row_offset),
        .i_byte_offset  (i_byte_offset),
        .i_pattern_byte (i_pattern_byte),
        .i_bit_count    (i_bit_count),
        .i_pixel_color  (i_pixel_color),
        .i_address      (i_address),
        .o_mem_req      (mem_req),
        .i_rd_data      (rd_data),
        .o_result       (result),
        .i_result_take  (result_take)
    );

    pfb_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    // load when the output register is empty or drains this cycle
    assign result_take = result.valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (result_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result_take) begin
            r_read_data <= result.data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;

endmodule
`default_nettype wire

### design/pfb_store.sv
// Frame store: 1024 x 8 memory, one write port and one read port.
// Read data is registered. Depends on pfb_pkg.
`default_nettype none
module pfb_store
    import pfb_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_mem_req i_req,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [STORE_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

### design/pfb_ctrl.sv
// Sequencer for the page framebuffer blitter: clearing sweep, per-pixel
// read-modify-write pipeline and store reads. Depends on pfb_pkg.
`default_nettype none
module pfb_ctrl
    import pfb_pkg::*;
#(
    parameter int PANEL_WIDTH  = 128,
    parameter int PANEL_HEIGHT = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [1:0]          i_operation,
    input  wire logic [7:0]          i_x_pos,
    input  wire logic [7:0]          i_y_pos,
    input  wire logic [7:0]          i_row_offset,
    input  wire logic [4:0]          i_byte_offset,
    input  wire logic [7:0]          i_pattern_byte,
    input  wire logic [3:0]          i_bit_count,
    input  wire logic                i_pixel_color,
    input  wire logic [STORE_AW-1:0] i_address,
    output t_mem_req                 o_mem_req,
    input  wire logic [7:0]          i_rd_data,
    output t_result                  o_result,
    input  wire logic                i_result_take
);

    t_state r_state, n_state;
    t_op    r_op, n_op;

    logic [7:0]          r_col_base, n_col_base;
    logic [IDX_W-1:0]    r_page_base, n_page_base;
    logic                r_row_ok, n_row_ok;
    logic [2:0]          r_bit, n_bit;
    logic                r_color, n_color;
    logic [7:0]          r_mask, n_mask;
    logic [2:0]          r_k, n_k;
    logic [2:0]          r_last_k, n_last_k;
    logic [STORE_AW-1:0] r_addr, n_addr;
    logic [STORE_AW-1:0] r_clr_addr, n_clr_addr;
    logic                r_clr_item, n_clr_item;

    // write-back stage of the read-modify-write
    logic                r_wb_valid, n_wb_valid;
    logic [STORE_AW-1:0] r_wb_idx, n_wb_idx;
    logic [2:0]          r_wb_bit, n_wb_bit;
    logic                r_wb_color, n_wb_color;

    logic [7:0]       in_row;
    logic [7:0]       pix_col;
    logic             pix_col_ok;
    logic [IDX_W-1:0] pix_idx;
    logic             pix_hit;
    logic [7:0]       wb_onehot;
    logic [7:0]       wb_data;

    function automatic logic [7:0] lead_mask(input logic [3:0] cnt);
        logic [7:0] m;
        if (cnt == 4'd0) begin
            m = 8'h00;
        end else if (cnt >= 4'd8) begin
            m = 8'hFF;
        end else begin
            m = ~(8'hFF >> cnt);
        end
        return m;
    endfunction

    assign in_row = (t_op'(i_operation) == OP_BLIT) ? (i_y_pos + i_row_offset) : i_y_pos;

    assign pix_col    = r_col_base + {5'd0, r_k};
    assign pix_col_ok = ({1'b0, pix_col} < 9'(PANEL_WIDTH));
    assign pix_idx    = r_page_base + {{(IDX_W-8){1'b0}}, pix_col};
    assign pix_hit    = r_mask[7] && r_row_ok && pix_col_ok
                        && (pix_idx < IDX_W'(STORE_DEPTH));

    assign wb_onehot = 8'd1 << r_wb_bit;
    assign wb_data   = r_wb_color ? (i_rd_data | wb_onehot) : (i_rd_data & ~wb_onehot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_clr_item <= 1'b0;
            r_wb_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_clr_item <= n_clr_item;
            r_wb_valid <= n_wb_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_col_base  <= n_col_base;
        r_page_base <= n_page_base;
        r_row_ok    <= n_row_ok;
        r_bit       <= n_bit;
        r_color     <= n_color;
        r_mask      <= n_mask;
        r_k         <= n_k;
        r_last_k    <= n_last_k;
        r_addr      <= n_addr;
        r_wb_idx    <= n_wb_idx;
        r_wb_bit    <= n_wb_bit;
        r_wb_color  <= n_wb_color;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_col_base  = r_col_base;
        n_page_base = r_page_base;
        n_row_ok    = r_row_ok;
        n_bit       = r_bit;
        n_color     = r_color;
        n_mask      = r_mask;
        n_k         = r_k;
        n_last_k    = r_last_k;
        n_addr      = r_addr;
        n_clr_addr  = r_clr_addr;
        n_clr_item  = r_clr_item;
        n_wb_valid  = 1'b0;
        n_wb_idx    = r_wb_idx;
        n_wb_bit    = r_wb_bit;
        n_wb_color  = r_wb_color;

        o_in_stall = 1'b1;
        o_result   = '{valid: 1'b0, data: 8'd0};

        o_mem_req.we    = r_wb_valid;
        o_mem_req.waddr = r_wb_idx;
        o_mem_req.wdata = wb_data;
        o_mem_req.re    = 1'b0;
        o_mem_req.raddr = pix_idx[STORE_AW-1:0];

        unique case (r_state)
            ST_CLEAR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_clr_addr;
                o_mem_req.wdata = 8'd0;
                n_clr_addr      = r_clr_addr + 1'b1;
                if (r_clr_addr == STORE_AW'(STORE_DEPTH - 1)) begin
                    n_state = r_clr_item ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_op        = t_op'(i_operation);
                    n_bit       = in_row[2:0];
                    n_row_ok    = ({1'b0, in_row} < 9'(PANEL_HEIGHT));
                    n_page_base = IDX_W'(in_row[7:3]) * IDX_W'(PANEL_WIDTH);
                    n_color     = i_pixel_color;
                    n_addr      = i_address;
                    n_k         = 3'd0;
                    unique case (t_op'(i_operation))
                        OP_CLEAR: begin
                            n_clr_addr = '0;
                            n_clr_item = 1'b1;
                            n_state    = ST_CLEAR;
                        end
                        OP_PLOT: begin
                            n_col_base = i_x_pos;
                            n_mask     = BYTE_MSB;
                            n_last_k   = 3'd0;
                            n_state    = ST_PIXEL;
                        end
                        OP_BLIT: begin
                            n_col_base = i_x_pos + {i_byte_offset, 3'd0};
                            n_mask     = i_pattern_byte & lead_mask(i_bit_count);
                            n_last_k   = 3'd7;
                            n_state    = ST_PIXEL;
                        end
                        OP_READ: begin
                            n_state = ST_READ;
                        end
                    endcase
                end
            end
            ST_PIXEL: begin
                // read this column byte; write it back next cycle
                o_mem_req.re = 1'b1;
                n_wb_valid   = pix_hit;
                n_wb_idx     = pix_idx[STORE_AW-1:0];
                n_wb_bit     = r_bit;
                n_wb_color   = r_color;
                n_mask       = {r_mask[6:0], 1'b0};
                n_k          = r_k + 3'd1;
                if (r_k == r_last_k) begin
                    n_state = ST_DONE;
                end
            end
            ST_READ: begin
                o_mem_req.re    = 1'b1;
                o_mem_req.raddr = r_addr;
                n_state         = ST_DONE;
            end
            ST_DONE: begin
                n_clr_item     = 1'b0;
                o_result.valid = 1'b1;
                o_result.data  = (r_op == OP_READ) ? i_rd_data : 8'd0;
                if (i_result_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
